// ===== src/rfcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcc_pkg
// Shared types and constants of the rgb frequency color classifier.
// ----------------------------------------------------------------------------
package rfcc_pkg;

	localparam int FREQ_BITS_DEF = 20;
	localparam int LEVEL_BITS    = 8;
	localparam int CFG_IDX_BITS  = 3;
	// clamp/window stage, scale stage, one divide stage per level bit
	localparam int LANE_LAT      = LEVEL_BITS + 2;
	localparam int MERGE_LAT     = 2;

	localparam int RED_LOW_RST    = 9000;
	localparam int RED_HIGH_RST   = 40000;
	localparam int GREEN_LOW_RST  = 8000;
	localparam int GREEN_HIGH_RST = 35000;
	localparam int BLUE_LOW_RST   = 7000;
	localparam int BLUE_HIGH_RST  = 36000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_RED_LOW    = 3'd0,
		REG_RED_HIGH   = 3'd1,
		REG_GREEN_LOW  = 3'd2,
		REG_GREEN_HIGH = 3'd3,
		REG_BLUE_LOW   = 3'd4,
		REG_BLUE_HIGH  = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		CLS_BLACK   = 4'd0,
		CLS_WHITE   = 4'd1,
		CLS_GREY    = 4'd2,
		CLS_RED     = 4'd3,
		CLS_BLUE    = 4'd4,
		CLS_GREEN   = 4'd5,
		CLS_YELLOW  = 4'd6,
		CLS_ORANGE  = 4'd7,
		CLS_PURPLE  = 4'd8,
		CLS_BROWN   = 4'd9,
		CLS_UNKNOWN = 4'd10
	} color_class_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] red;
		logic [LEVEL_BITS-1:0] green;
		logic [LEVEL_BITS-1:0] blue;
		color_class_t          cls;
	} result_t;

endpackage

// ===== src/rfcc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcc_lane
// One color channel: clamp to the calibration window, scale by 255 and
// divide by the window width in a pipelined restoring divider.
// ----------------------------------------------------------------------------
module rfcc_lane #(
	parameter int FREQ_BITS = rfcc_pkg::FREQ_BITS_DEF
) (
	input  logic                               clk,
	input  logic [FREQ_BITS-1:0]               freq,
	input  logic [FREQ_BITS-1:0]               low_hz,
	input  logic [FREQ_BITS-1:0]               high_hz,
	output logic [rfcc_pkg::LEVEL_BITS-1:0]    level
);
	import rfcc_pkg::*;

	localparam int W  = FREQ_BITS;
	localparam int L  = LEVEL_BITS;
	localparam int NW = W + L;

	logic [W-1:0]  clamped;
	logic [W-1:0]  diff_s1;
	logic [W-1:0]  den_s1;

	logic [NW-1:0] rem_s [0:L];
	logic [W-1:0]  dv_s  [0:L];
	logic [L-1:0]  quo_s [0:L];

	always_comb begin
		if (freq < low_hz) begin
			clamped = low_hz;
		end else if (freq > high_hz) begin
			clamped = high_hz;
		end else begin
			clamped = freq;
		end
	end

	// empty window gives 0 / 1 so the divider returns zero
	always_ff @(posedge clk) begin
		if (high_hz <= low_hz) begin
			diff_s1 <= '0;
			den_s1  <= {{(W-1){1'b0}}, 1'b1};
		end else begin
			diff_s1 <= clamped - low_hz;
			den_s1  <= high_hz - low_hz;
		end
	end

	// diff * 255 as diff * 256 - diff
	always_ff @(posedge clk) begin
		rem_s[0] <= {diff_s1, {L{1'b0}}} - {{L{1'b0}}, diff_s1};
		dv_s[0]  <= den_s1;
		quo_s[0] <= '0;
	end

	for (genvar j = 0; j < L; j++) begin : g_div
		localparam int K = L - 1 - j;
		logic [NW-1:0] sub;
		logic          ge;
		logic [L-1:0]  qbit;

		assign sub  = {{L{1'b0}}, dv_s[j]} << K;
		assign ge   = rem_s[j] >= sub;
		assign qbit = L'(ge) << K;

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? rem_s[j] - sub : rem_s[j];
			dv_s[j+1]  <= dv_s[j];
			quo_s[j+1] <= quo_s[j] | qbit;
		end
	end

	assign level = quo_s[L];

endmodule

// ===== src/rfcc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcc_merge
// Combines the three channel levels: max/min and rule hits, then the
// ordered rule list picks the color class.
// ----------------------------------------------------------------------------
module rfcc_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [rfcc_pkg::LEVEL_BITS-1:0] red,
	input  logic [rfcc_pkg::LEVEL_BITS-1:0] green,
	input  logic [rfcc_pkg::LEVEL_BITS-1:0] blue,
	output logic                            done,
	output rfcc_pkg::result_t               result
);
	import rfcc_pkg::*;

	typedef struct packed {
		logic black;
		logic white;
		logic grey;
		logic red;
		logic blue;
		logic green;
		logic yellow;
		logic orange;
		logic purple;
		logic brown;
	} rule_hits_t;

	logic [LEVEL_BITS-1:0] mx;
	logic [LEVEL_BITS-1:0] mn;
	logic [LEVEL_BITS-1:0] span;
	rule_hits_t            hits;

	logic                  vld_s1;
	rule_hits_t            hits_s1;
	logic [LEVEL_BITS-1:0] red_s1;
	logic [LEVEL_BITS-1:0] green_s1;
	logic [LEVEL_BITS-1:0] blue_s1;
	color_class_t          cls;

	logic                  done_q;
	result_t               result_q;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) begin
			mx = green;
		end
		if (blue > mx) begin
			mx = blue;
		end
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		span = mx - mn;

		hits.black  = mx < 8'd40;
		hits.white  = (mx > 8'd200) && (span < 8'd30);
		hits.grey   = span < 8'd15;
		hits.red    = (red > 8'd180) && (green < 8'd80) && (blue < 8'd80);
		hits.blue   = (blue > 8'd150) && (red < 8'd80) && (green < 8'd120);
		hits.green  = (green > 8'd150) && (red < 8'd100) && (blue < 8'd120);
		hits.yellow = (red > 8'd180) && (green > 8'd160) && (blue < 8'd90);
		hits.orange = (red > 8'd180) && (green > 8'd80) && (green < 8'd140)
			&& (blue < 8'd80);
		hits.purple = (red > 8'd120) && (blue > 8'd140) && (green < 8'd90);
		hits.brown  = (red > 8'd120) && (green < 8'd100) && (blue < 8'd90);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		hits_s1  <= hits;
		red_s1   <= red;
		green_s1 <= green;
		blue_s1  <= blue;
	end

	// first matching rule wins
	always_comb begin
		priority if (hits_s1.black) begin
			cls = CLS_BLACK;
		end else if (hits_s1.white) begin
			cls = CLS_WHITE;
		end else if (hits_s1.grey) begin
			cls = CLS_GREY;
		end else if (hits_s1.red) begin
			cls = CLS_RED;
		end else if (hits_s1.blue) begin
			cls = CLS_BLUE;
		end else if (hits_s1.green) begin
			cls = CLS_GREEN;
		end else if (hits_s1.yellow) begin
			cls = CLS_YELLOW;
		end else if (hits_s1.orange) begin
			cls = CLS_ORANGE;
		end else if (hits_s1.purple) begin
			cls = CLS_PURPLE;
		end else if (hits_s1.brown) begin
			cls = CLS_BROWN;
		end else begin
			cls = CLS_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_q.red   <= red_s1;
		result_q.green <= green_s1;
		result_q.blue  <= blue_s1;
		result_q.cls   <= cls;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/rgb_frequency_color_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_frequency_color_classifier
// Scales three sensor frequencies to bytes and classifies the color.
// ----------------------------------------------------------------------------
// A request is taken in every cycle that start is high; busy is always low.
// The result of each request shows on the result ports with done high for
// one cycle, and the receiver has no way to hold it. Each request passes
// through the per-channel pipeline (window clamp, scale by 255, then an
// 8-stage restoring divider, one quotient bit per stage) followed by two
// merge stages for max/min and the rule list.
// The calibration window registers may be rewritten only when no request
// is in flight.
module rgb_frequency_color_classifier #(
	parameter int FREQ_BITS = rfcc_pkg::FREQ_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [FREQ_BITS-1:0]              red_freq,
	input  logic [FREQ_BITS-1:0]              green_freq,
	input  logic [FREQ_BITS-1:0]              blue_freq,
	input  logic                              cfg_we,
	input  logic [rfcc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [FREQ_BITS-1:0]              cfg_data,
	output logic                              done,
	output logic [rfcc_pkg::LEVEL_BITS-1:0]   red_level,
	output logic [rfcc_pkg::LEVEL_BITS-1:0]   green_level,
	output logic [rfcc_pkg::LEVEL_BITS-1:0]   blue_level,
	output logic [3:0]                        color_class
);
	import rfcc_pkg::*;

	logic [FREQ_BITS-1:0]  red_low_q;
	logic [FREQ_BITS-1:0]  red_high_q;
	logic [FREQ_BITS-1:0]  green_low_q;
	logic [FREQ_BITS-1:0]  green_high_q;
	logic [FREQ_BITS-1:0]  blue_low_q;
	logic [FREQ_BITS-1:0]  blue_high_q;

	logic                  accept;
	logic [LANE_LAT-1:0]   vld_q;
	logic [LEVEL_BITS-1:0] red_lvl;
	logic [LEVEL_BITS-1:0] green_lvl;
	logic [LEVEL_BITS-1:0] blue_lvl;
	result_t               result;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_low_q    <= FREQ_BITS'(RED_LOW_RST);
			red_high_q   <= FREQ_BITS'(RED_HIGH_RST);
			green_low_q  <= FREQ_BITS'(GREEN_LOW_RST);
			green_high_q <= FREQ_BITS'(GREEN_HIGH_RST);
			blue_low_q   <= FREQ_BITS'(BLUE_LOW_RST);
			blue_high_q  <= FREQ_BITS'(BLUE_HIGH_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RED_LOW: begin
					red_low_q <= cfg_data;
				end
				REG_RED_HIGH: begin
					red_high_q <= cfg_data;
				end
				REG_GREEN_LOW: begin
					green_low_q <= cfg_data;
				end
				REG_GREEN_HIGH: begin
					green_high_q <= cfg_data;
				end
				REG_BLUE_LOW: begin
					blue_low_q <= cfg_data;
				end
				REG_BLUE_HIGH: begin
					blue_high_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// request valid travels alongside the lane pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LANE_LAT-2:0], accept};
		end
	end

	rfcc_lane #(.FREQ_BITS(FREQ_BITS)) u_lane_red (
		.clk     (clk),
		.freq    (red_freq),
		.low_hz  (red_low_q),
		.high_hz (red_high_q),
		.level   (red_lvl)
	);

	rfcc_lane #(.FREQ_BITS(FREQ_BITS)) u_lane_green (
		.clk     (clk),
		.freq    (green_freq),
		.low_hz  (green_low_q),
		.high_hz (green_high_q),
		.level   (green_lvl)
	);

	rfcc_lane #(.FREQ_BITS(FREQ_BITS)) u_lane_blue (
		.clk     (clk),
		.freq    (blue_freq),
		.low_hz  (blue_low_q),
		.high_hz (blue_high_q),
		.level   (blue_lvl)
	);

	rfcc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_q[LANE_LAT-1]),
		.red      (red_lvl),
		.green    (green_lvl),
		.blue     (blue_lvl),
		.done     (done),
		.result   (result)
	);

	assign red_level   = result.red;
	assign green_level = result.green;
	assign blue_level  = result.blue;
	assign color_class = result.cls;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##12 done)
		else $error("result strobe missing after request");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> color_class <= CLS_UNKNOWN)
		else $error("class code out of range");

	a_black_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(done && color_class == CLS_BLACK) |->
		(red_level < 8'd40 && green_level < 8'd40 && blue_level < 8'd40))
		else $error("black class with a bright channel");

	a_white_bright: assert property (@(posedge clk) disable iff (!arst_n)
		(done && color_class == CLS_WHITE) |->
		(red_level > 8'd170 && green_level > 8'd170 && blue_level > 8'd170))
		else $error("white class with a dim channel");

endmodule

// ===== tb/color_class_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_class_checker
// Watches the request, configuration and result ports of the classifier.
// It keeps its own copy of the six window registers and works out the
// levels and color class of every accepted request. Each result is then
// compared in order, field by field.
// ----------------------------------------------------------------------------
module color_class_checker #(
	parameter int FREQ_BITS = rfcc_pkg::FREQ_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [FREQ_BITS-1:0]              red_freq,
	input  logic [FREQ_BITS-1:0]              green_freq,
	input  logic [FREQ_BITS-1:0]              blue_freq,
	input  logic                              cfg_we,
	input  logic [rfcc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [FREQ_BITS-1:0]              cfg_data,
	input  logic                              done,
	input  logic [rfcc_pkg::LEVEL_BITS-1:0]   red_level,
	input  logic [rfcc_pkg::LEVEL_BITS-1:0]   green_level,
	input  logic [rfcc_pkg::LEVEL_BITS-1:0]   blue_level,
	input  logic [3:0]                        color_class,
	output int                                pending,
	output int                                fail_count
);
	import rfcc_pkg::*;

	localparam int NUM_REGS = int'(REG_BLUE_HIGH) + 1;

	// rule thresholds on the scaled bytes
	localparam int DARK_LIMIT   = 40;
	localparam int WHITE_FLOOR  = 200;
	localparam int WHITE_SPREAD = 30;
	localparam int GREY_SPREAD  = 15;
	localparam int HOT          = 180;
	localparam int STRONG       = 150;
	localparam int BRIGHT       = 160;
	localparam int WARM         = 120;
	localparam int HALF         = 100;
	localparam int DIM          = 90;
	localparam int FAINT        = 80;
	localparam int MID_HIGH     = 140;

	logic [FREQ_BITS-1:0] window_regs [0:NUM_REGS-1];
	result_t              expected_colors [$];

	function automatic logic [LEVEL_BITS-1:0] freq_to_level(
		input logic [FREQ_BITS-1:0] freq,
		input logic [FREQ_BITS-1:0] lo,
		input logic [FREQ_BITS-1:0] hi
	);
		logic [FREQ_BITS-1:0]   clamped;
		logic [FREQ_BITS+7:0]   scaled;
		logic [FREQ_BITS+7:0]   quotient;
		if (hi <= lo)
			return '0;
		clamped = (freq < lo) ? lo : ((freq > hi) ? hi : freq);
		scaled = clamped - lo;
		scaled = scaled * 255;
		quotient = scaled / (hi - lo);
		return quotient[LEVEL_BITS-1:0];
	endfunction

	function automatic color_class_t classify_levels(
		input logic [LEVEL_BITS-1:0] r,
		input logic [LEVEL_BITS-1:0] g,
		input logic [LEVEL_BITS-1:0] b
	);
		int peak;
		int floor_lvl;
		int spread;
		peak = int'(r);
		floor_lvl = int'(r);
		if (g > peak) peak = int'(g);
		if (b > peak) peak = int'(b);
		if (g < floor_lvl) floor_lvl = int'(g);
		if (b < floor_lvl) floor_lvl = int'(b);
		spread = peak - floor_lvl;
		if (peak < DARK_LIMIT) return CLS_BLACK;
		if (peak > WHITE_FLOOR && spread < WHITE_SPREAD) return CLS_WHITE;
		if (spread < GREY_SPREAD) return CLS_GREY;
		if (r > HOT && g < FAINT && b < FAINT) return CLS_RED;
		if (b > STRONG && r < FAINT && g < WARM) return CLS_BLUE;
		if (g > STRONG && r < HALF && b < WARM) return CLS_GREEN;
		if (r > HOT && g > BRIGHT && b < DIM) return CLS_YELLOW;
		if (r > HOT && g > FAINT && g < MID_HIGH && b < FAINT) return CLS_ORANGE;
		if (r > WARM && b > MID_HIGH && g < DIM) return CLS_PURPLE;
		if (r > WARM && g < HALF && b < DIM) return CLS_BROWN;
		return CLS_UNKNOWN;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			window_regs[REG_RED_LOW]    = FREQ_BITS'(RED_LOW_RST);
			window_regs[REG_RED_HIGH]   = FREQ_BITS'(RED_HIGH_RST);
			window_regs[REG_GREEN_LOW]  = FREQ_BITS'(GREEN_LOW_RST);
			window_regs[REG_GREEN_HIGH] = FREQ_BITS'(GREEN_HIGH_RST);
			window_regs[REG_BLUE_LOW]   = FREQ_BITS'(BLUE_LOW_RST);
			window_regs[REG_BLUE_HIGH]  = FREQ_BITS'(BLUE_HIGH_RST);
			expected_colors.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (expected_colors.size() == 0) begin
					$error("color result with no request waiting");
					fail_count++;
				end else begin
					want = expected_colors.pop_front();
					if (red_level !== want.red) begin
						$error("red_level: expected %0d, got %0d", want.red, red_level);
						fail_count++;
					end
					if (green_level !== want.green) begin
						$error("green_level: expected %0d, got %0d", want.green, green_level);
						fail_count++;
					end
					if (blue_level !== want.blue) begin
						$error("blue_level: expected %0d, got %0d", want.blue, blue_level);
						fail_count++;
					end
					if (color_class !== want.cls) begin
						$error("color_class: expected %0d, got %0d", want.cls, color_class);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				want.red   = freq_to_level(red_freq, window_regs[REG_RED_LOW],
					window_regs[REG_RED_HIGH]);
				want.green = freq_to_level(green_freq, window_regs[REG_GREEN_LOW],
					window_regs[REG_GREEN_HIGH]);
				want.blue  = freq_to_level(blue_freq, window_regs[REG_BLUE_LOW],
					window_regs[REG_BLUE_HIGH]);
				want.cls   = classify_levels(want.red, want.green, want.blue);
				expected_colors.push_back(want);
			end
			// writes to indexes past the last window register are dropped
			if (cfg_we && cfg_index <= REG_BLUE_HIGH)
				window_regs[cfg_index] = cfg_data;
		end
		pending = expected_colors.size();
	end

endmodule

// ===== tb/tb_rgb_frequency_color_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_frequency_color_classifier
// Sends sensor frequency requests to the classifier under several window
// settings: reset values, random windows, full range, empty and very narrow
// windows. Directed requests hit every color class and the rule edges, then
// random requests mix target levels, near-window and raw frequencies.
// ----------------------------------------------------------------------------
module tb_rgb_frequency_color_classifier;
	import rfcc_pkg::*;

	localparam int FB           = FREQ_BITS_DEF;
	localparam int NUM_REGS     = int'(REG_BLUE_HIGH) + 1;
	localparam int NUM_INDEXES  = 2 ** CFG_IDX_BITS;
	localparam int SETTLE_CYCLES = LANE_LAT + MERGE_LAT + 4;
	localparam logic [FB-1:0] FREQ_MAX = '1;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [FB-1:0]           red_freq;
	logic [FB-1:0]           green_freq;
	logic [FB-1:0]           blue_freq;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [FB-1:0]           cfg_data;
	logic                    done;
	logic [LEVEL_BITS-1:0]   red_level;
	logic [LEVEL_BITS-1:0]   green_level;
	logic [LEVEL_BITS-1:0]   blue_level;
	logic [3:0]              color_class;
	int                      pending;
	int                      fail_count;

	// window settings as last written, used to aim requests at given levels
	logic [FB-1:0] win [0:NUM_REGS-1];
	bit            quiet;

	rgb_frequency_color_classifier #(.FREQ_BITS(FB)) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red_freq    (red_freq),
		.green_freq  (green_freq),
		.blue_freq   (blue_freq),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.color_class (color_class)
	);

	color_class_checker #(.FREQ_BITS(FB)) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red_freq    (red_freq),
		.green_freq  (green_freq),
		.blue_freq   (blue_freq),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.color_class (color_class),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [FB-1:0] near_window(input int ch);
		longint lo;
		longint hi;
		longint f;
		lo = longint'(win[2*ch]);
		hi = longint'(win[2*ch+1]);
		if (hi < lo) begin
			f = lo;
			lo = hi;
			hi = f;
		end
		f = lo - 64 + $urandom_range(int'(hi - lo) + 128);
		if (f < 0) f = 0;
		if (f > longint'(FREQ_MAX)) f = longint'(FREQ_MAX);
		return f[FB-1:0];
	endfunction

	// smallest frequency that scales to the wanted byte, for wide windows
	function automatic logic [FB-1:0] level_freq(input int ch, input int lvl);
		longint lo;
		longint hi;
		longint f;
		lo = longint'(win[2*ch]);
		hi = longint'(win[2*ch+1]);
		if (hi <= lo)
			return near_window(ch);
		f = lo + (lvl * (hi - lo) + 254) / 255;
		return f[FB-1:0];
	endfunction

	// half uniform, half close to one of the rule thresholds
	function automatic int pick_level();
		int t;
		if ($urandom_range(1))
			return $urandom_range(255);
		case ($urandom_range(11))
			0:       t = 15;
			1:       t = 30;
			2:       t = 40;
			3:       t = 80;
			4:       t = 90;
			5:       t = 100;
			6:       t = 120;
			7:       t = 140;
			8:       t = 150;
			9:       t = 160;
			10:      t = 180;
			default: t = 200;
		endcase
		return t + $urandom_range(4) - 2;
	endfunction

	task automatic send(input logic [FB-1:0] r, input logic [FB-1:0] g,
		input logic [FB-1:0] b);
		bit taken;
		while (!quiet && $urandom_range(99) < 8) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		red_freq   <= r;
		green_freq <= g;
		blue_freq  <= b;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_levels(input int r, input int g, input int b);
		send(level_freq(0, r), level_freq(1, g), level_freq(2, b));
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	task automatic program_windows(input logic [FB-1:0] rl, input logic [FB-1:0] rh,
		input logic [FB-1:0] gl, input logic [FB-1:0] gh,
		input logic [FB-1:0] bl, input logic [FB-1:0] bh);
		int stray;
		drain();
		win[REG_RED_LOW]    = rl;
		win[REG_RED_HIGH]   = rh;
		win[REG_GREEN_LOW]  = gl;
		win[REG_GREEN_HIGH] = gh;
		win[REG_BLUE_LOW]   = bl;
		win[REG_BLUE_HIGH]  = bh;
		for (int i = 0; i < NUM_REGS; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_BITS-1:0];
			cfg_data  <= win[i];
		end
		// a write past the register list must leave the windows alone
		stray = $urandom_range(NUM_REGS, NUM_INDEXES - 1);
		@(posedge clk);
		cfg_index <= stray[CFG_IDX_BITS-1:0];
		cfg_data  <= FB'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int mode;
		int base;
		repeat (count) begin
			mode = $urandom_range(99);
			if (mode < 40) begin
				send_levels(pick_level(), pick_level(), pick_level());
			end else if (mode < 60) begin
				// tight spreads around the white and grey edges
				base = $urandom_range(220);
				send_levels(base + $urandom_range(35), base + $urandom_range(35),
					base + $urandom_range(35));
			end else if (mode < 80) begin
				send(near_window(0), near_window(1), near_window(2));
			end else begin
				send(FB'($urandom), FB'($urandom), FB'($urandom));
			end
		end
	endtask

	initial begin
		int lo;
		arst_n     = 1'b0;
		start      = 1'b0;
		red_freq   = '0;
		green_freq = '0;
		blue_freq  = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		quiet      = 1'b0;
		win[REG_RED_LOW]    = FB'(RED_LOW_RST);
		win[REG_RED_HIGH]   = FB'(RED_HIGH_RST);
		win[REG_GREEN_LOW]  = FB'(GREEN_LOW_RST);
		win[REG_GREEN_HIGH] = FB'(GREEN_HIGH_RST);
		win[REG_BLUE_LOW]   = FB'(BLUE_LOW_RST);
		win[REG_BLUE_HIGH]  = FB'(BLUE_HIGH_RST);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and window edges under the reset windows
		send('0, '0, '0);
		send(FREQ_MAX, FREQ_MAX, FREQ_MAX);
		send(FB'(RED_LOW_RST), FB'(GREEN_LOW_RST), FB'(BLUE_LOW_RST));
		send(FB'(RED_HIGH_RST), FB'(GREEN_HIGH_RST), FB'(BLUE_HIGH_RST));
		send('0, FREQ_MAX, '0);
		// one request per class
		send_levels(10, 20, 30);
		send_levels(220, 230, 240);
		send_levels(100, 105, 110);
		send_levels(200, 50, 50);
		send_levels(50, 60, 200);
		send_levels(50, 200, 60);
		send_levels(200, 200, 50);
		send_levels(200, 100, 50);
		send_levels(150, 50, 180);
		send_levels(150, 50, 50);
		send_levels(150, 150, 50);
		// rule edges: dark limit, white floor and spread, grey spread, orange green bounds
		send_levels(39, 39, 39);
		send_levels(40, 40, 40);
		send_levels(200, 200, 200);
		send_levels(201, 172, 201);
		send_levels(201, 171, 201);
		send_levels(100, 114, 100);
		send_levels(100, 115, 100);
		send_levels(200, 80, 50);
		send_levels(200, 140, 50);
		run_random(300);

		lo = $urandom_range(2**19);
		program_windows(FB'(lo), FB'(lo + $urandom_range(256, 2**19 - 1)),
			FB'($urandom_range(2**19)), FB'(2**19 + $urandom_range(2**19 - 1)),
			FB'($urandom_range(1000)), FB'($urandom_range(2000, 2**19)));
		run_random(350);

		// widest windows, with the sender never pausing
		program_windows('0, FREQ_MAX, '0, FREQ_MAX, '0, FREQ_MAX);
		quiet = 1'b1;
		run_random(300);
		quiet = 1'b0;

		// empty red and green windows: equal bounds and inverted bounds
		program_windows(FB'(5000), FB'(5000), FREQ_MAX, '0, FB'(BLUE_LOW_RST),
			FB'(BLUE_HIGH_RST));
		send('0, '0, '0);
		send(FREQ_MAX, FREQ_MAX, FREQ_MAX);
		run_random(150);

		// very narrow windows, 1 to 300 frequency units wide
		lo = $urandom_range(2**19);
		program_windows(FB'(lo), FB'(lo + 1), FB'(lo), FB'(lo + $urandom_range(2, 40)),
			FB'(lo + 7), FB'(lo + 7 + $urandom_range(200, 300)));
		run_random(200);

		program_windows(FB'(RED_LOW_RST), FB'(RED_HIGH_RST), FB'(GREEN_LOW_RST),
			FB'(GREEN_HIGH_RST), FB'(BLUE_LOW_RST), FB'(BLUE_HIGH_RST));
		run_random(300);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rfcc_pkg.sv
src/rfcc_lane.sv
src/rfcc_merge.sv
src/rgb_frequency_color_classifier.sv
tb/color_class_checker.sv
tb/tb_rgb_frequency_color_classifier.sv
